### src/silpd_pkg.sv
`default_nettype none
package silpd_pkg;

    localparam int FRACTION_EXTRA = 14;
    localparam int SAMPLE_WIDTH   = 16;
    localparam int PRECISE_WIDTH  = 32;
    localparam int SHIFT_WIDTH    = 4;
    localparam int CFG_INDEX_WIDTH = 2;

    typedef logic signed [SAMPLE_WIDTH-1:0]  sample_t;
    typedef logic signed [PRECISE_WIDTH-1:0] precise_t;
    typedef logic        [SHIFT_WIDTH-1:0]   shift_t;
    typedef logic        [CFG_INDEX_WIDTH-1:0] cfg_index_t;

    typedef enum logic [1:0] {
        CMD_ADD_REGULAR = 2'd0,
        CMD_ADD_PRECISE = 2'd1,
        CMD_SEED        = 2'd2
    } command_t;

    localparam cfg_index_t CFG_SHIFT_A = cfg_index_t'(0);
    localparam cfg_index_t CFG_SHIFT_B = cfg_index_t'(1);

    localparam shift_t SHIFT_A_RESET = shift_t'(2);
    localparam shift_t SHIFT_B_RESET = shift_t'(1);
    localparam shift_t SHIFT_A_MIN   = shift_t'(2);

    // Saturation bounds of the regular format, expressed in the extended width.
    localparam precise_t SAT_MAX =
        {{(PRECISE_WIDTH-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam precise_t SAT_MIN =
        {{(PRECISE_WIDTH-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

    typedef struct packed {
        shift_t shift_a;
        shift_t shift_b;
    } cfg_t;

    typedef struct packed {
        precise_t y0;
        precise_t y1;
        precise_t y2;
    } outputs_t;

    typedef struct packed {
        sample_t  filtered_regular;
        precise_t filtered_precise;
        logic     peak_high;
        logic     peak_low;
        sample_t  peak_value;
    } result_t;

    function automatic precise_t to_precise(input sample_t s);
        precise_t v;
        v = precise_t'(s);
        return v <<< FRACTION_EXTRA;
    endfunction

    // Round to nearest (ties up), then saturate to the regular format.
    function automatic sample_t to_regular(input precise_t v);
        precise_t q;
        q = (v >>> FRACTION_EXTRA) + precise_t'({1'b0, v[FRACTION_EXTRA-1]});
        if (q > SAT_MAX) begin
            q = SAT_MAX;
        end else if (q < SAT_MIN) begin
            q = SAT_MIN;
        end
        return q[SAMPLE_WIDTH-1:0];
    endfunction

endpackage
`default_nettype wire

### src/silpd_cfg.sv
`default_nettype none
module silpd_cfg (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_valid,
    input  wire silpd_pkg::cfg_index_t  cfg_index,
    input  wire silpd_pkg::shift_t      cfg_data,
    output silpd_pkg::cfg_t             cfg
);

    silpd_pkg::shift_t shift_a_reg, shift_a_next;
    silpd_pkg::shift_t shift_b_reg, shift_b_next;

    always_comb begin
        shift_a_next = shift_a_reg;
        shift_b_next = shift_b_reg;
        if (cfg_valid) begin
            case (cfg_index)
                silpd_pkg::CFG_SHIFT_A: shift_a_next = cfg_data;
                silpd_pkg::CFG_SHIFT_B: shift_b_next = cfg_data;
                default: ; // drop writes to unknown registers
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_a_reg <= silpd_pkg::SHIFT_A_RESET;
            shift_b_reg <= silpd_pkg::SHIFT_B_RESET;
        end else begin
            shift_a_reg <= shift_a_next;
            shift_b_reg <= shift_b_next;
        end
    end

    assign cfg.shift_a = shift_a_reg;
    assign cfg.shift_b = shift_b_reg;

endmodule
`default_nettype wire

### src/silpd_filter.sv
`default_nettype none
module silpd_filter (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 advance,
    input  wire logic [1:0]           command,
    input  wire silpd_pkg::sample_t   sample_regular,
    input  wire silpd_pkg::precise_t  sample_precise,
    input  wire silpd_pkg::cfg_t      cfg,
    output silpd_pkg::outputs_t       hist
);

    silpd_pkg::precise_t x0_reg, x1_reg, x2_reg;
    silpd_pkg::precise_t y0_reg, y1_reg, y2_reg;
    silpd_pkg::precise_t x0_next, x1_next, x2_next;
    silpd_pkg::precise_t y0_next, y1_next, y2_next;
    silpd_pkg::precise_t new_x;
    silpd_pkg::precise_t seed;
    silpd_pkg::shift_t   a;
    silpd_pkg::shift_t   b;
    logic                do_add;

    assign a    = (cfg.shift_a < silpd_pkg::SHIFT_A_MIN) ? silpd_pkg::SHIFT_A_MIN : cfg.shift_a;
    assign b    = cfg.shift_b;
    assign seed = silpd_pkg::to_precise(sample_regular);

    always_comb begin
        do_add  = 1'b0;
        new_x   = seed;
        x0_next = x0_reg;
        x1_next = x1_reg;
        x2_next = x2_reg;
        y0_next = y0_reg;
        y1_next = y1_reg;
        y2_next = y2_reg;
        case (command)
            silpd_pkg::CMD_ADD_REGULAR: begin
                do_add = 1'b1;
            end
            silpd_pkg::CMD_ADD_PRECISE: begin
                do_add = 1'b1;
                new_x  = sample_precise;
            end
            silpd_pkg::CMD_SEED: begin
                x0_next = seed;
                x1_next = seed;
                x2_next = seed;
                y0_next = seed;
                y1_next = seed;
                y2_next = seed;
            end
            default: ; // hold history
        endcase
        if (do_add) begin
            x0_next = new_x;
            x1_next = x0_reg;
            x2_next = x1_reg;
            y1_next = y0_reg;
            y2_next = y1_reg;
            y0_next = y0_reg + y0_reg - y1_reg
                    - (y0_reg >>> b) + (y1_reg >>> b)
                    + (new_x >>> a) + (x0_reg >>> (a - 4'd1)) + (x1_reg >>> a)
                    - (y1_reg >>> (a - 4'd2));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x0_reg <= '0;
            x1_reg <= '0;
            x2_reg <= '0;
            y0_reg <= '0;
            y1_reg <= '0;
            y2_reg <= '0;
        end else if (advance) begin
            x0_reg <= x0_next;
            x1_reg <= x1_next;
            x2_reg <= x2_next;
            y0_reg <= y0_next;
            y1_reg <= y1_next;
            y2_reg <= y2_next;
        end
    end

    assign hist.y0 = y0_next;
    assign hist.y1 = y1_next;
    assign hist.y2 = y2_next;

endmodule
`default_nettype wire

### src/silpd_peak.sv
`default_nettype none
module silpd_peak (
    input  wire silpd_pkg::outputs_t hist,
    output silpd_pkg::result_t       result
);

    logic hi;
    logic lo;

    // y1 peaks when above (below) y0 and not below (above) y2.
    assign hi = (hist.y0 < hist.y1) && !(hist.y1 < hist.y2);
    assign lo = (hist.y1 < hist.y0) && !(hist.y2 < hist.y1);

    assign result.filtered_regular = silpd_pkg::to_regular(hist.y0);
    assign result.filtered_precise = hist.y0;
    assign result.peak_high        = hi;
    assign result.peak_low         = lo;
    assign result.peak_value       = (hi || lo) ? silpd_pkg::to_regular(hist.y1) : '0;

endmodule
`default_nettype wire

### src/shift_iir_lowpass_peak_detect.sv
// Second-order shift-coefficient low-pass IIR with peak detection.
// Path: input transaction to input register, then to result register.
// Throughput: 1 transaction per cycle unless m_ready stalls; set by the history loop.
// Reset (aresetn low, synchronous): history cleared to zero, shift_a = 2, shift_b = 1,
// both pipeline stages emptied.
`default_nettype none
module shift_iir_lowpass_peak_detect (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // input channel
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [1:0]             s_command,
    input  wire silpd_pkg::sample_t     s_sample_regular,
    input  wire silpd_pkg::precise_t    s_sample_precise,
    // result channel
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output silpd_pkg::sample_t          m_filtered_regular,
    output silpd_pkg::precise_t         m_filtered_precise,
    output logic                        m_peak_high,
    output logic                        m_peak_low,
    output silpd_pkg::sample_t          m_peak_value,
    // configuration write channel
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire silpd_pkg::cfg_index_t  cfg_index,
    input  wire silpd_pkg::shift_t      cfg_data
);

    // Input stage: one registered transaction waiting to enter the filter.
    logic                 in_valid_reg, in_valid_next;
    logic [1:0]           command_reg;
    silpd_pkg::sample_t   sample_regular_reg;
    silpd_pkg::precise_t  sample_precise_reg;

    // Result stage.
    logic                 out_valid_reg, out_valid_next;
    silpd_pkg::result_t   result_reg;

    silpd_pkg::cfg_t      cfg;
    silpd_pkg::outputs_t  hist;
    silpd_pkg::result_t   result;

    logic out_free;
    logic advance;
    logic in_take;

    // The result register frees when empty or when its transaction is taken.
    assign out_free = !out_valid_reg || m_ready;
    // Move the input stage into the filter only when the result has room.
    assign advance  = in_valid_reg && out_free;
    // Accept a new transaction when the input stage is empty or draining this cycle.
    assign s_ready  = !in_valid_reg || out_free;
    assign in_take  = s_valid && s_ready;

    // Configuration must be written only while idle; the block does not enforce this, so always accept.
    assign cfg_ready = 1'b1;

    silpd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // History registers advance together with the result register, so the
    // next transaction sees the history left by this one.
    silpd_filter u_filter (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (advance),
        .command        (command_reg),
        .sample_regular (sample_regular_reg),
        .sample_precise (sample_precise_reg),
        .cfg            (cfg),
        .hist           (hist)
    );

    silpd_peak u_peak (
        .hist   (hist),
        .result (result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on transaction, hold otherwise.
    always_ff @(posedge aclk) begin
        if (in_take) begin
            command_reg        <= s_command;
            sample_regular_reg <= s_sample_regular;
            sample_precise_reg <= s_sample_precise;
        end
        if (advance) begin
            result_reg <= result;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_filtered_regular = result_reg.filtered_regular;
    assign m_filtered_precise = result_reg.filtered_precise;
    assign m_peak_high        = result_reg.peak_high;
    assign m_peak_low         = result_reg.peak_low;
    assign m_peak_value       = result_reg.peak_value;

endmodule
`default_nettype wire

### tb/shift_iir_lowpass_peak_detect_checker.sv
`timescale 1ns / 1ps
module shift_iir_lowpass_peak_detect_checker
    import silpd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    input  wire logic       s_ready,
    input  wire logic [1:0] s_command,
    input  wire sample_t    s_sample_regular,
    input  wire precise_t   s_sample_precise,
    input  wire logic       m_valid,
    input  wire logic       m_ready,
    input  wire sample_t    m_filtered_regular,
    input  wire precise_t   m_filtered_precise,
    input  wire logic       m_peak_high,
    input  wire logic       m_peak_low,
    input  wire sample_t    m_peak_value,
    input  wire logic       cfg_valid,
    input  wire logic       cfg_ready,
    input  wire cfg_index_t cfg_index,
    input  wire shift_t     cfg_data,
    output int              samples_taken,
    output int              results_taken,
    output int              mismatches
);

    precise_t x_hist [3];
    precise_t y_hist [3];
    shift_t   coef_a;
    shift_t   coef_b;
    result_t  filter_outputs_due [$];
    int       mismatch_total;

    assign mismatches = mismatch_total;

    function automatic precise_t widen_sample(input sample_t s);
        precise_t w;
        w = s;
        return w <<< FRACTION_EXTRA;
    endfunction

    // Round half up, then clamp to the regular range.
    function automatic sample_t round_to_sample(input precise_t v);
        longint q;
        longint hi_lim;
        hi_lim = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
        q = longint'(v >>> FRACTION_EXTRA) + longint'(v[FRACTION_EXTRA-1]);
        if (q > hi_lim) begin
            q = hi_lim;
        end else if (q < -hi_lim - 1) begin
            q = -hi_lim - 1;
        end
        return sample_t'(q);
    endfunction

    function automatic result_t filter_step(input logic [1:0] cmd, input sample_t r,
                                            input precise_t p);
        result_t  res;
        precise_t fresh;
        logic     advance;
        int       a;
        int       b;
        a = (coef_a < SHIFT_A_MIN) ? int'(SHIFT_A_MIN) : int'(coef_a);
        b = int'(coef_b);
        advance = 1'b0;
        fresh = '0;
        case (command_t'(cmd))
            CMD_ADD_REGULAR: begin
                fresh = widen_sample(r);
                advance = 1'b1;
            end
            CMD_ADD_PRECISE: begin
                fresh = p;
                advance = 1'b1;
            end
            CMD_SEED: begin
                for (int k = 0; k < 3; k++) begin
                    x_hist[k] = widen_sample(r);
                    y_hist[k] = widen_sample(r);
                end
            end
            default: ;
        endcase
        if (advance) begin
            x_hist[2] = x_hist[1];
            x_hist[1] = x_hist[0];
            x_hist[0] = fresh;
            y_hist[2] = y_hist[1];
            y_hist[1] = y_hist[0];
            y_hist[0] = y_hist[1] + y_hist[1] - y_hist[2]
                      - (y_hist[1] >>> b) + (y_hist[2] >>> b)
                      + (x_hist[0] >>> a) + (x_hist[1] >>> (a - 1)) + (x_hist[2] >>> a)
                      - (y_hist[2] >>> (a - 2));
        end
        res.filtered_regular = round_to_sample(y_hist[0]);
        res.filtered_precise = y_hist[0];
        res.peak_high = (y_hist[0] < y_hist[1]) && (y_hist[1] >= y_hist[2]);
        res.peak_low  = (y_hist[0] > y_hist[1]) && (y_hist[1] <= y_hist[2]);
        res.peak_value = (res.peak_high || res.peak_low) ? round_to_sample(y_hist[1]) : '0;
        return res;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatch_total++;
        end
    endtask

    initial mismatch_total = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                x_hist[k] = '0;
                y_hist[k] = '0;
            end
            coef_a = SHIFT_A_RESET;
            coef_b = SHIFT_B_RESET;
            filter_outputs_due.delete();
            samples_taken <= 0;
            results_taken <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SHIFT_A: coef_a = cfg_data;
                    CFG_SHIFT_B: coef_b = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                filter_outputs_due.push_back(filter_step(s_command, s_sample_regular,
                                                         s_sample_precise));
                samples_taken <= samples_taken + 1;
            end
            if (m_valid && m_ready) begin
                results_taken <= results_taken + 1;
                if (filter_outputs_due.size() == 0) begin
                    $error("result transaction with no sample outstanding");
                    mismatch_total++;
                end else begin
                    result_t want;
                    want = filter_outputs_due.pop_front();
                    check_field("filtered_regular", want.filtered_regular,
                                m_filtered_regular);
                    check_field("filtered_precise", want.filtered_precise,
                                m_filtered_precise);
                    check_field("peak_high", want.peak_high, m_peak_high);
                    check_field("peak_low", want.peak_low, m_peak_low);
                    check_field("peak_value", want.peak_value, m_peak_value);
                end
            end
        end
    end

endmodule

### tb/shift_iir_lowpass_peak_detect_test.sv
`timescale 1ns / 1ps
module shift_iir_lowpass_peak_detect_test;
    import silpd_pkg::*;

    // Command code the block must treat as a no-op on its history.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    // Index values past the two real registers; writes to them must be harmless.
    localparam cfg_index_t CFG_SPARE_2 = cfg_index_t'(2);
    localparam cfg_index_t CFG_SPARE_3 = cfg_index_t'(3);

    localparam int IDLE_LIMIT       = 1000;
    localparam int DRAIN_CYCLES     = 8;
    localparam int NUM_PHASES       = 10;
    localparam int RANDOM_PER_PHASE = 158;

    // Coefficient settings per phase; covers shift_a below its floor and both extremes.
    localparam shift_t PHASE_A [NUM_PHASES] = '{4'd0, 4'd15, 4'd1, 4'd15, 4'd2,
                                                4'd7, 4'd4, 4'd2, 4'd11, 4'd3};
    localparam shift_t PHASE_B [NUM_PHASES] = '{4'd15, 4'd0, 4'd0, 4'd15, 4'd0,
                                                4'd3, 4'd8, 4'd1, 4'd5, 4'd12};

    typedef enum int {READY_ALWAYS, READY_COIN, READY_BURSTY} ready_mode_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_command = '0;
    sample_t    s_sample_regular = '0;
    precise_t   s_sample_precise = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    sample_t    m_filtered_regular;
    precise_t   m_filtered_precise;
    logic       m_peak_high;
    logic       m_peak_low;
    sample_t    m_peak_value;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    cfg_index_t cfg_index = '0;
    shift_t     cfg_data = '0;

    int samples_taken;
    int results_taken;
    int mismatches;

    int burst_left = 0;
    int quiet_cycles = 0;

    always #4 aclk = ~aclk;

    shift_iir_lowpass_peak_detect dut (.*);

    shift_iir_lowpass_peak_detect_checker checker_i (.*);

    // Offer one sample transaction and hold it until the block takes it.
    // Bursts of back-to-back transactions are separated by random gaps; valid stays
    // high across a burst so it is never dropped and raised in the same step.
    task automatic send_sample(input logic [1:0] cmd, input sample_t r, input precise_t p);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_command <= cmd;
        s_sample_regular <= r;
        s_sample_precise <= p;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and wait until every outstanding result has been taken.
    task automatic drain_results();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (samples_taken != results_taken) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Reprogram both shifts while idle; also poke an unmapped index with junk.
    task automatic set_shifts(input shift_t a, input shift_t b);
        cfg_index_t idx [3];
        shift_t     val [3];
        idx = '{($urandom_range(0, 1) != 0) ? CFG_SPARE_2 : CFG_SPARE_3,
                CFG_SHIFT_A, CFG_SHIFT_B};
        val = '{shift_t'($urandom), a, b};
        drain_results();
        for (int k = 0; k < 3; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data <= val[k];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    // Mostly a slowly wandering signal so the filter output rises and falls and
    // produces peaks; the rest is full-range noise, extended samples, seeds and
    // the unused command.
    task automatic random_traffic(input int count);
        int level;
        int trend;
        int pick;
        level = int'($urandom_range(0, 8000)) - 4000;
        trend = int'($urandom_range(50, 1500));
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 68) begin
                if ($urandom_range(0, 11) == 0) begin
                    trend = ($urandom_range(0, 1) != 0) ? int'($urandom_range(50, 1500))
                                                        : -int'($urandom_range(50, 1500));
                end
                level += trend + int'($urandom_range(0, 400)) - 200;
                if (level > 32767) begin
                    level = 32767;
                    trend = -trend;
                end else if (level < -32768) begin
                    level = -32768;
                    trend = -trend;
                end
                send_sample(CMD_ADD_REGULAR, sample_t'(level), precise_t'($urandom));
            end else if (pick < 80) begin
                send_sample(CMD_ADD_REGULAR, sample_t'($urandom), precise_t'($urandom));
            end else if (pick < 86) begin
                // Extended sample close to the current level, with random fraction bits.
                send_sample(CMD_ADD_PRECISE, sample_t'($urandom),
                            (precise_t'(level) <<< FRACTION_EXTRA)
                            + precise_t'($urandom_range(0, (1 << FRACTION_EXTRA) - 1)));
            end else if (pick < 92) begin
                send_sample(CMD_ADD_PRECISE, sample_t'($urandom), precise_t'($urandom));
            end else if (pick < 97) begin
                level = int'(sample_t'($urandom));
                send_sample(CMD_SEED, sample_t'(level), precise_t'($urandom));
            end else begin
                send_sample(CMD_UNUSED, sample_t'($urandom), precise_t'($urandom));
            end
        end
    endtask

    // Result-side back-pressure: switch modes at random between always ready,
    // a coin toss per cycle, and occasional stalls.
    ready_mode_t ready_mode = READY_ALWAYS;
    int          mode_age = 0;
    int          stall_left = 0;

    always @(posedge aclk) begin
        if (mode_age == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 2));
            mode_age = $urandom_range(50, 300);
        end
        mode_age--;
        case (ready_mode)
            READY_ALWAYS: m_ready <= 1'b1;
            READY_COIN:   m_ready <= 1'($urandom_range(0, 1));
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    m_ready <= 1'b0;
                end else if ($urandom_range(0, 9) == 0) begin
                    stall_left = $urandom_range(0, 11);
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        endcase
    end

    // Watchdog: end the run if no transaction moves on any channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == IDLE_LIMIT) begin
            $error("no transaction for %0d cycles", IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes of both sample formats, saturation and wrap of the
        // extended sums, the unused command, rounding ties in both directions,
        // seeding, and a small signal that forms a positive then a negative peak.
        send_sample(CMD_SEED, 16'sh7fff, precise_t'($urandom));
        send_sample(CMD_ADD_REGULAR, -16'sh8000, precise_t'($urandom));
        send_sample(CMD_ADD_REGULAR, -16'sh8000, precise_t'($urandom));
        send_sample(CMD_ADD_REGULAR, 16'sh7fff, precise_t'($urandom));
        send_sample(CMD_ADD_REGULAR, 16'sh0000, precise_t'($urandom));
        send_sample(CMD_ADD_PRECISE, sample_t'($urandom), 32'sh7fffffff);
        send_sample(CMD_ADD_PRECISE, sample_t'($urandom), 32'sh7fffffff);
        send_sample(CMD_ADD_PRECISE, sample_t'($urandom), 32'sh80000000);
        send_sample(CMD_ADD_PRECISE, sample_t'($urandom), 32'sh80000000);
        send_sample(CMD_UNUSED, sample_t'($urandom), precise_t'($urandom));
        send_sample(CMD_SEED, -16'sh8000, precise_t'($urandom));
        send_sample(CMD_UNUSED, 16'sh7fff, 32'sh7fffffff);
        send_sample(CMD_SEED, 16'sh0000, 32'sh00000000);
        send_sample(CMD_ADD_PRECISE, 16'sh0000, 32'sh00002000);
        send_sample(CMD_ADD_PRECISE, 16'sh0000, -32'sh00002000);
        send_sample(CMD_ADD_REGULAR, 16'sh0001, precise_t'($urandom));
        send_sample(CMD_ADD_REGULAR, -16'sh0001, precise_t'($urandom));
        send_sample(CMD_SEED, 16'sh0000, precise_t'($urandom));
        send_sample(CMD_ADD_REGULAR, 16'sd400, precise_t'($urandom));
        send_sample(CMD_ADD_REGULAR, 16'sd800, precise_t'($urandom));
        send_sample(CMD_ADD_REGULAR, -16'sd600, precise_t'($urandom));
        send_sample(CMD_ADD_REGULAR, -16'sd900, precise_t'($urandom));
        send_sample(CMD_ADD_REGULAR, 16'sd700, precise_t'($urandom));
        send_sample(CMD_ADD_REGULAR, 16'sd700, precise_t'($urandom));

        // Random traffic under each coefficient setting.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_shifts(PHASE_A[ph], PHASE_B[ph]);
            random_traffic(RANDOM_PER_PHASE);
        end

        drain_results();
        $display("Run covered %0d sample transactions and %0d result transactions",
                 samples_taken, results_taken);
        $display("across %0d shift settings with stalls on both channels", NUM_PHASES + 1);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
